@@ design/ilp_pkg.sv @@
package ilp_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned AccW  = 64;

  // Character codes the parser looks for
  localparam logic [CharW-1:0] ChTerm   = 8'h00;
  localparam logic [CharW-1:0] ChZero   = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChOne    = 8'h31;  // '1'
  localparam logic [CharW-1:0] ChNine   = 8'h39;  // '9'
  localparam logic [CharW-1:0] ChUpA    = 8'h41;  // 'A'
  localparam logic [CharW-1:0] ChUpF    = 8'h46;  // 'F'
  localparam logic [CharW-1:0] ChUpX    = 8'h58;  // 'X'
  localparam logic [CharW-1:0] ChLoA    = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ChLoB    = 8'h62;  // 'b'
  localparam logic [CharW-1:0] ChLoF    = 8'h66;  // 'f'
  localparam logic [CharW-1:0] ChLoX    = 8'h78;  // 'x'

  // Offset that maps the low nibble of A-F / a-f onto 10-15
  localparam logic [3:0] HexLetterOfs = 4'd9;

  typedef enum logic [1:0] {
    MODE_DEC  = 2'd0,
    MODE_HEX  = 2'd1,
    MODE_BIN  = 2'd2,
    MODE_STOP = 2'd3
  } mode_t;

  typedef struct packed {
    logic       is_term;
    logic       is_dec;
    logic       is_hex_letter;
    logic       is_bin;
    logic       is_hex_prefix;
    logic       is_bin_prefix;
    logic [3:0] digit;
  } char_class_t;

endpackage

@@ design/ilp_char_decode.sv @@
module ilp_char_decode
  import ilp_pkg::*;
(
  input  logic [CharW-1:0] char_code,
  output char_class_t      cls
);

  logic dec;
  logic hex_up;
  logic hex_lo;

  assign dec    = (char_code >= ChZero) && (char_code <= ChNine);
  assign hex_up = (char_code >= ChUpA) && (char_code <= ChUpF);
  assign hex_lo = (char_code >= ChLoA) && (char_code <= ChLoF);

  always_comb begin
    cls               = '0;
    cls.is_term       = (char_code == ChTerm);
    cls.is_dec        = dec;
    cls.is_hex_letter = hex_up || hex_lo;
    cls.is_bin        = (char_code == ChZero) || (char_code == ChOne);
    cls.is_hex_prefix = (char_code == ChLoX) || (char_code == ChUpX);
    cls.is_bin_prefix = (char_code == ChLoB);
    if (hex_up || hex_lo) begin
      cls.digit = char_code[3:0] + HexLetterOfs;
    end else begin
      cls.digit = char_code[3:0];
    end
  end

endmodule

@@ design/ilp_accum.sv @@
module ilp_accum
  import ilp_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  char_class_t     cls,
  output logic [AccW-1:0] acc
);

  logic [AccW-1:0] acc_r;
  logic [AccW-1:0] acc_nxt;
  mode_t           mode_r;
  mode_t           mode_nxt;
  logic [AccW-1:0] digit_ext;

  assign digit_ext = {{(AccW-4){1'b0}}, cls.digit};

  // Next mode
  always_comb begin
    mode_nxt = mode_r;
    if (cls.is_term) begin
      mode_nxt = MODE_DEC;
    end else begin
      unique case (mode_r)
        MODE_DEC: begin
          if (cls.is_dec) begin
            mode_nxt = MODE_DEC;
          end else if (cls.is_hex_prefix) begin
            mode_nxt = MODE_HEX;
          end else if (cls.is_bin_prefix) begin
            mode_nxt = MODE_BIN;
          end else begin
            mode_nxt = MODE_STOP;
          end
        end
        MODE_HEX: begin
          if (!(cls.is_dec || cls.is_hex_letter)) begin
            mode_nxt = MODE_STOP;
          end
        end
        MODE_BIN: begin
          if (!cls.is_bin) begin
            mode_nxt = MODE_STOP;
          end
        end
        MODE_STOP: mode_nxt = MODE_STOP;
        default:   mode_nxt = MODE_STOP;
      endcase
    end
  end

  // Next accumulator: times ten is x8 + x2
  always_comb begin
    acc_nxt = acc_r;
    if (cls.is_term) begin
      acc_nxt = '0;
    end else begin
      unique case (mode_r)
        MODE_DEC: begin
          if (cls.is_dec) begin
            acc_nxt = (acc_r << 3) + (acc_r << 1) + digit_ext;
          end
        end
        MODE_HEX: begin
          if (cls.is_dec || cls.is_hex_letter) begin
            acc_nxt = (acc_r << 4) | digit_ext;
          end
        end
        MODE_BIN: begin
          if (cls.is_bin) begin
            acc_nxt = (acc_r << 1) | digit_ext;
          end
        end
        MODE_STOP: acc_nxt = acc_r;
        default:   acc_nxt = acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      mode_r <= MODE_DEC;
    end else if (step) begin
      acc_r  <= acc_nxt;
      mode_r <= mode_nxt;
    end
  end

  assign acc = acc_r;

endmodule

@@ design/integer_literal_parser.sv @@
// Integer literal parser: takes one character per request on the in_ channel
// and builds a 64-bit value, decimal by default, hex after an 'x' or 'X',
// binary after a 'b'; any other character stops the parse and the rest of the
// literal is ignored. A zero character ends the literal: one request with the
// value (two's complement, wrapping modulo 2^64) leaves on the out_ channel and
// the parser starts over from zero in decimal. Every character passes through
// an input register and then the accumulator update; a new character is
// taken every cycle, stalling only when a terminator meets a full result
// register whose request is not taken. A terminator passes the input register,
// and the accumulator value is then loaded into the result register.
module integer_literal_parser
  import ilp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CharW-1:0]       in_char_code,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [AccW-1:0] out_value
);

  logic             s1_vld_r;
  logic             s1_vld_nxt;
  logic [CharW-1:0] s1_char_r;
  char_class_t      s1_cls;
  logic             s1_adv;
  logic             term_adv;
  logic             out_free;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [AccW-1:0]  out_value_r;
  logic [AccW-1:0]  acc;

  ilp_char_decode u_decode (
    .char_code (s1_char_r),
    .cls       (s1_cls)
  );

  ilp_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .cls   (s1_cls),
    .acc   (acc)
  );

  // Only a terminator needs room in the result register
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_vld_r && (!s1_cls.is_term || out_free);
  assign term_adv = s1_adv && s1_cls.is_term;
  assign in_ready = !s1_vld_r || s1_adv;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_valid && in_ready) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (term_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_code;
    end
    if (term_adv) begin
      out_value_r <= acc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = $signed(out_value_r);

  a_term_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    term_adv |=> out_valid_r && (out_value_r == $past(acc)))
    else $error("terminator did not load the result register");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    term_adv |=> (acc == '0))
    else $error("accumulator not cleared after terminator");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_cls.is_term) |-> in_ready)
    else $error("stall on a non-terminator character");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s1_adv) |=> $stable(acc) && s1_vld_r)
    else $error("accumulator moved while stalled");

endmodule
